### rtl/core/wgs_pkg.sv
// weighted gram-schmidt unit: shared constants, codes, types and helpers
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package wgs_pkg;

	localparam int DATA_W       = 32;
	localparam int ACC_W        = 64;
	localparam int FRAC_W       = 24;
	localparam int IDX_W        = 6;
	localparam int LEN_CFG_W    = 7;
	localparam int CNT_CFG_W    = 5;
	localparam int NORM_W       = 31;
	localparam int CFG_W        = 31;
	localparam int REG_IDX_W    = 2;
	localparam int SKIP_W       = 5;
	localparam int ROOT_W       = 28;
	localparam int RAD_W        = 2 * ROOT_W;
	localparam int QUO_W        = DATA_W + FRAC_W;
	localparam int MAX_LEN_DEF  = 64;
	localparam int MAX_VECS_DEF = 16;

	localparam logic [LEN_CFG_W-1:0] VECTOR_LENGTH_RST = 7'd64;
	localparam logic [CNT_CFG_W-1:0] VECTOR_COUNT_RST  = 5'd16;
	localparam logic [NORM_W-1:0]    MIN_NORM_RST      = 31'd1;
	localparam logic [SKIP_W-1:0]    SKIP_MAX          = 5'd31;

	localparam logic [REG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_VECTOR_COUNT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_NORM      = 2'd2;

	localparam logic signed [ACC_W-1:0]  SAT_HI  = 64'sd2147483647;
	localparam logic signed [ACC_W-1:0]  SAT_LO  = -64'sd2147483648;
	localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;

	typedef enum logic [1:0] {
		CMD_LOAD_BASIS  = 2'd0,
		CMD_LOAD_WEIGHT = 2'd1,
		CMD_RUN         = 2'd2,
		CMD_READ        = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MAC_W,
		MAC_X,
		MAC_UPD
	} mac_kind_t;

	typedef struct packed {
		logic      valid;
		mac_kind_t kind;
		logic      first;
		logic      y_res;
	} mac_ctl_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_READ,
		S_RUN_INIT,
		S_COL,
		S_COPY,
		S_PROJ,
		S_DOT_W,
		S_DOT_GAP,
		S_DOT_X,
		S_DOT_END,
		S_UPD,
		S_DRAIN,
		S_SQRT_WAIT,
		S_CHECK,
		S_DIV_RD,
		S_DIV_GO,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_HI) begin
			r = DATA_MAX;
		end else if (v < SAT_LO) begin
			r = DATA_MIN;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/wgs_store.sv
// basis, weight and result memories, with registered read data
// depends on wgs_pkg
`timescale 1ns / 1ps

module wgs_store import wgs_pkg::*; #(
	parameter int MAX_LEN  = MAX_LEN_DEF,
	parameter int MAX_VECS = MAX_VECS_DEF,
	localparam int LEN_AW  = $clog2(MAX_LEN),
	localparam int VEC_AW  = (MAX_VECS > 1) ? $clog2(MAX_VECS) : 1,
	localparam int RES_AW  = VEC_AW + LEN_AW,
	localparam int W_AW    = 2 * LEN_AW
) (
	input  logic                     clk,
	input  logic                     basis_we,
	input  logic [RES_AW-1:0]        basis_waddr,
	input  logic signed [DATA_W-1:0] basis_wdata,
	input  logic [RES_AW-1:0]        basis_raddr,
	output logic signed [DATA_W-1:0] basis_rdata,
	input  logic                     weight_we,
	input  logic [W_AW-1:0]          weight_waddr,
	input  logic signed [DATA_W-1:0] weight_wdata,
	input  logic [W_AW-1:0]          weight_raddr,
	output logic signed [DATA_W-1:0] weight_rdata,
	input  logic                     res_we,
	input  logic [RES_AW-1:0]        res_waddr,
	input  logic signed [DATA_W-1:0] res_wdata,
	input  logic [RES_AW-1:0]        res_raddr_a,
	output logic signed [DATA_W-1:0] res_rdata_a,
	input  logic [RES_AW-1:0]        res_raddr_b,
	output logic signed [DATA_W-1:0] res_rdata_b
);

	localparam int RES_DEPTH = 1 << RES_AW;
	localparam int W_DEPTH   = 1 << W_AW;

	logic [DATA_W-1:0] basis_mem  [RES_DEPTH];
	logic [DATA_W-1:0] weight_mem [W_DEPTH];
	logic [DATA_W-1:0] res_mem    [RES_DEPTH];

	always_ff @(posedge clk) begin
		if (basis_we) begin
			basis_mem[basis_waddr] <= basis_wdata;
		end
		basis_rdata <= basis_mem[basis_raddr];
	end

	always_ff @(posedge clk) begin
		if (weight_we) begin
			weight_mem[weight_waddr] <= weight_wdata;
		end
		weight_rdata <= weight_mem[weight_raddr];
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_waddr] <= res_wdata;
		end
		res_rdata_a <= res_mem[res_raddr_a];
		res_rdata_b <= res_mem[res_raddr_b];
	end

endmodule

### rtl/core/wgs_mac.sv
// two stage multiply, round and accumulate datapath for dots and updates
// depends on wgs_pkg; fed by wgs_store read data
`timescale 1ns / 1ps

module wgs_mac import wgs_pkg::*; #(
	parameter int LEN_AW = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 op,
	input  logic [LEN_AW-1:0]        op_row,
	input  logic signed [DATA_W-1:0] w_rdata,
	input  logic signed [DATA_W-1:0] basis_rdata,
	input  logic signed [DATA_W-1:0] res_a_rdata,
	input  logic signed [DATA_W-1:0] res_b_rdata,
	input  logic signed [DATA_W-1:0] coef,
	output logic signed [ACC_W-1:0]  tot,
	output logic                     upd_we,
	output logic [LEN_AW-1:0]        upd_row,
	output logic signed [DATA_W-1:0] upd_data,
	output logic                     busy
);

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

	mac_ctl_t                 ctl_s1, ctl_s2;
	logic [LEN_AW-1:0]        row_s1, row_s2;
	logic signed [DATA_W-1:0] r_s2;
	logic signed [ACC_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]  acc_q, tot_q;
	logic signed [DATA_W-1:0] opa, opb;
	logic signed [ACC_W-1:0]  prod;
	logic signed [ACC_W-1:0]  rnd;

	always_comb begin
		opa = '0;
		opb = '0;
		case (ctl_s1.kind)
			MAC_W: begin
				opa = w_rdata;
				opb = ctl_s1.y_res ? res_a_rdata : basis_rdata;
			end
			MAC_X: begin
				opa = res_a_rdata;
				opb = sat32(acc_q);
			end
			MAC_UPD: begin
				opa = coef;
				opb = res_a_rdata;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod = opa * opb;
	assign rnd  = (prod_s2 + RND_HALF) >>> FRAC_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= op;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1  <= op_row;
		row_s2  <= row_s1;
		r_s2    <= res_b_rdata;
		prod_s2 <= prod;
		if (ctl_s2.valid && ctl_s2.kind == MAC_W) begin
			acc_q <= ctl_s2.first ? rnd : acc_q + rnd;
		end
		if (ctl_s2.valid && ctl_s2.kind == MAC_X) begin
			tot_q <= ctl_s2.first ? rnd : tot_q + rnd;
		end
	end

	assign tot      = tot_q;
	assign upd_we   = ctl_s2.valid && (ctl_s2.kind == MAC_UPD);
	assign upd_row  = row_s2;
	assign upd_data = sat32(ACC_W'(r_s2) - rnd);
	assign busy     = ctl_s1.valid | ctl_s2.valid;

endmodule

### rtl/core/wgs_sqrt.sv
// bit serial integer square root, one root bit per cycle
// depends on wgs_pkg
`timescale 1ns / 1ps

module wgs_sqrt import wgs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  value,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q, done_q;
	logic [REM_W-1:0]  rem_sh, trial, rem_nx;
	logic              ge;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign rem_nx = ge ? rem_sh - trial : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= rem_nx;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/core/wgs_div.sv
// restoring divider for normalising, one quotient bit per cycle, saturating
// depends on wgs_pkg
`timescale 1ns / 1ps

module wgs_div import wgs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] x,
	input  logic [ROOT_W-1:0]        divisor,
	output logic                     done,
	output logic signed [DATA_W-1:0] quot
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [QUO_W-1:0]  dvd_q;
	logic [ROOT_W-1:0] rem_q, dsr_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q, done_q;
	logic [DATA_W-1:0] mag;
	logic [ROOT_W:0]   rem_sh, rem_nx;
	logic              ge, hi;

	assign mag    = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
	assign rem_sh = {rem_q, dvd_q[QUO_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
	assign hi     = |dvd_q[QUO_W-1:DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag, {FRAC_W{1'b0}}};
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= x[DATA_W-1];
		end else if (run_q) begin
			dvd_q <= {dvd_q[QUO_W-2:0], ge};
			rem_q <= rem_nx[ROOT_W-1:0];
		end
	end

	always_comb begin
		if (neg_q) begin
			if (hi || (dvd_q[DATA_W-1] && (|dvd_q[DATA_W-2:0]))) begin
				quot = DATA_MIN;
			end else begin
				quot = -$signed(dvd_q[DATA_W-1:0]);
			end
		end else begin
			if (hi || dvd_q[DATA_W-1]) begin
				quot = DATA_MAX;
			end else begin
				quot = $signed(dvd_q[DATA_W-1:0]);
			end
		end
	end

	assign done = done_q;

endmodule

### rtl/core/weighted_gram_schmidt_unit.sv
// weighted gram-schmidt unit: command sequencer, registers and top level
// depends on wgs_pkg, wgs_store, wgs_mac, wgs_sqrt, wgs_div
//
// channel   direction  ports
// command   in         start/busy, command, row_index, col_index, element_value
// result    out        done, result_value, skipped_columns, is_run_status
// config    in         cfg_write, cfg_index, cfg_data
//
// loads give no beat; a read gives its beat after passing through S_READ
// a run takes, per column i, a copy pass, (i+1) dots, i update passes,
// a root and check, and n divides
// the run is set by the shared multiplier pipe and the bit serial root and divider
// reset clears control and registers only; memories hold what was loaded
// a beat on the result side is one cycle wide and cannot be held off
`timescale 1ns / 1ps

module weighted_gram_schmidt_unit import wgs_pkg::*; #(
	parameter int MAX_LEN  = MAX_LEN_DEF,
	parameter int MAX_VECS = MAX_VECS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               command,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [DATA_W-1:0] element_value,
	output logic                     done,
	output logic signed [DATA_W-1:0] result_value,
	output logic [SKIP_W-1:0]        skipped_columns,
	output logic                     is_run_status,
	input  logic                     cfg_write,
	input  logic [REG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int LEN_AW = $clog2(MAX_LEN);
	localparam int VEC_AW = (MAX_VECS > 1) ? $clog2(MAX_VECS) : 1;
	localparam int LEN_CW = $clog2(MAX_LEN + 1);
	localparam int VEC_CW = $clog2(MAX_VECS + 1);
	localparam int RES_AW = VEC_AW + LEN_AW;
	localparam int W_AW   = 2 * LEN_AW;

	state_t state_q, state_d, after_q;

	logic [LEN_CFG_W-1:0] vector_length_q;
	logic [CNT_CFG_W-1:0] vector_count_q;
	logic [NORM_W-1:0]    min_norm_q;

	logic [VEC_CW-1:0] i_q, j_q, m_q, run_m_q, m_eff;
	logic [LEN_AW-1:0] k_q, l_q, copy_k_s1;
	logic [LEN_CW-1:0] n_q, run_n_q, n_eff;
	logic              dot_norm_q, copy_v_s1, rd_ok_q;
	logic [SKIP_W-1:0] skip_count_q;
	logic              done_q, is_run_status_q;
	logic signed [DATA_W-1:0] result_value_q, c_q;

	logic              accept, k_last, l_last, skip_col;
	cmd_t              cmd;
	logic [LEN_AW-1:0] in_row, in_col_w;
	logic [VEC_AW-1:0] in_col_b, i_a, j_a;
	logic              row_ok, colb_ok, colw_ok, rd_ok;

	logic [RES_AW-1:0] basis_raddr, res_raddr_a, res_raddr_b, res_waddr;
	logic [W_AW-1:0]   weight_raddr;
	logic signed [DATA_W-1:0] basis_rdata, weight_rdata, res_rdata_a, res_rdata_b;
	logic signed [DATA_W-1:0] res_wdata;
	logic              basis_we, weight_we, res_we;

	mac_ctl_t                 mac_op;
	logic signed [ACC_W-1:0]  mac_tot;
	logic                     upd_we, mac_busy;
	logic [LEN_AW-1:0]        upd_row;
	logic signed [DATA_W-1:0] upd_data;

	logic                     sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]        root;
	logic signed [DATA_W-1:0] n2_sat;
	logic [NORM_W-1:0]        n2_pos;
	logic [RAD_W-1:0]         sqrt_value;

	logic                     div_start, div_done, div_wr, copy_issue;
	logic signed [DATA_W-1:0] div_quot;

	assign accept   = start && !busy;
	assign cmd      = cmd_t'(command);
	assign in_row   = LEN_AW'(row_index);
	assign in_col_w = LEN_AW'(col_index);
	assign in_col_b = VEC_AW'(col_index);
	assign row_ok   = 32'(row_index) < MAX_LEN;
	assign colb_ok  = 32'(col_index) < MAX_VECS;
	assign colw_ok  = 32'(col_index) < MAX_LEN;
	assign rd_ok    = (32'(row_index) < 32'(run_n_q)) && (32'(col_index) < 32'(run_m_q));
	assign i_a      = VEC_AW'(i_q);
	assign j_a      = VEC_AW'(j_q);

	assign n_eff  = (32'(vector_length_q) > MAX_LEN) ? LEN_CW'(MAX_LEN) : LEN_CW'(vector_length_q);
	assign m_eff  = (32'(vector_count_q) > MAX_VECS) ? VEC_CW'(MAX_VECS) : VEC_CW'(vector_count_q);
	assign k_last = (LEN_CW'(k_q) + LEN_CW'(1)) == n_q;
	assign l_last = (LEN_CW'(l_q) + LEN_CW'(1)) == n_q;

	assign n2_sat     = sat32(mac_tot);
	assign n2_pos     = n2_sat[DATA_W-1] ? '0 : n2_sat[NORM_W-1:0];
	assign sqrt_value = RAD_W'({n2_pos, {FRAC_W{1'b0}}});
	assign skip_col   = (root == '0) || (NORM_W'(root) < min_norm_q);

	// loads
	assign basis_we  = accept && (cmd == CMD_LOAD_BASIS) && row_ok && colb_ok;
	assign weight_we = accept && (cmd == CMD_LOAD_WEIGHT) && row_ok && colw_ok;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q <= VECTOR_LENGTH_RST;
			vector_count_q  <= VECTOR_COUNT_RST;
			min_norm_q      <= MIN_NORM_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_VECTOR_LENGTH: vector_length_q <= cfg_data[LEN_CFG_W-1:0];
				REG_VECTOR_COUNT:  vector_count_q  <= cfg_data[CNT_CFG_W-1:0];
				REG_MIN_NORM:      min_norm_q      <= cfg_data[NORM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		basis_raddr  = {i_a, l_q};
		weight_raddr = {k_q, l_q};
		res_raddr_a  = {i_a, k_q};
		res_raddr_b  = {i_a, k_q};
		mac_op       = '0;
		copy_issue   = 1'b0;
		sqrt_start   = 1'b0;
		div_start    = 1'b0;
		div_wr       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				res_raddr_a = {in_col_b, in_row};
				if (accept && cmd == CMD_RUN) begin
					state_d = S_RUN_INIT;
				end else if (accept && cmd == CMD_READ) begin
					state_d = S_READ;
				end
			end
			S_READ:     state_d = S_IDLE;
			S_RUN_INIT: state_d = (n_eff == '0) ? S_DONE : S_COL;
			S_COL:      state_d = (i_q == m_q) ? S_DONE : S_COPY;
			S_COPY: begin
				basis_raddr = {i_a, k_q};
				copy_issue  = 1'b1;
				if (k_last) begin
					state_d = S_DRAIN;
				end
			end
			S_PROJ: state_d = S_DOT_W;
			S_DOT_W: begin
				res_raddr_a  = {i_a, l_q};
				mac_op.valid = 1'b1;
				mac_op.kind  = MAC_W;
				mac_op.first = (l_q == '0);
				mac_op.y_res = dot_norm_q;
				if (l_last) begin
					state_d = S_DOT_GAP;
				end
			end
			S_DOT_GAP: state_d = S_DOT_X;
			S_DOT_X: begin
				res_raddr_a  = {j_a, k_q};
				mac_op.valid = 1'b1;
				mac_op.kind  = MAC_X;
				mac_op.first = (k_q == '0);
				state_d      = k_last ? S_DRAIN : S_DOT_W;
			end
			S_DRAIN: begin
				if (!mac_busy && !copy_v_s1) begin
					state_d = after_q;
				end
			end
			S_DOT_END: begin
				sqrt_start = dot_norm_q;
				state_d    = dot_norm_q ? S_SQRT_WAIT : S_UPD;
			end
			S_UPD: begin
				res_raddr_a  = {j_a, k_q};
				res_raddr_b  = {i_a, k_q};
				mac_op.valid = 1'b1;
				mac_op.kind  = MAC_UPD;
				if (k_last) begin
					state_d = S_DRAIN;
				end
			end
			S_SQRT_WAIT: begin
				if (sqrt_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK:  state_d = skip_col ? S_COL : S_DIV_RD;
			S_DIV_RD: state_d = S_DIV_GO;
			S_DIV_GO: begin
				div_start = 1'b1;
				state_d   = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				div_wr = div_done;
				if (div_done) begin
					state_d = k_last ? S_COL : S_DIV_RD;
				end
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_q         <= S_IDLE;
			i_q             <= '0;
			j_q             <= '0;
			k_q             <= '0;
			l_q             <= '0;
			n_q             <= '0;
			m_q             <= '0;
			run_n_q         <= '0;
			run_m_q         <= '0;
			dot_norm_q      <= 1'b0;
			rd_ok_q         <= 1'b0;
			copy_v_s1       <= 1'b0;
			skip_count_q    <= '0;
			done_q          <= 1'b0;
			is_run_status_q <= 1'b0;
			result_value_q  <= '0;
			c_q             <= '0;
		end else begin
			copy_v_s1 <= copy_issue;
			done_q    <= 1'b0;
			case (state_q)
				S_IDLE: rd_ok_q <= rd_ok;
				S_READ: begin
					done_q          <= 1'b1;
					is_run_status_q <= 1'b0;
					result_value_q  <= rd_ok_q ? res_rdata_a : '0;
				end
				S_RUN_INIT: begin
					n_q     <= n_eff;
					m_q     <= m_eff;
					run_n_q <= n_eff;
					run_m_q <= m_eff;
					i_q     <= '0;
					if (n_eff == '0) begin
						skip_count_q <= (32'(m_eff) > 32'(SKIP_MAX)) ? SKIP_MAX : SKIP_W'(m_eff);
					end else begin
						skip_count_q <= '0;
					end
				end
				S_COL: k_q <= '0;
				S_COPY: begin
					k_q <= k_last ? '0 : k_q + LEN_AW'(1);
					if (k_last) begin
						j_q     <= '0;
						after_q <= S_PROJ;
					end
				end
				S_PROJ: begin
					k_q        <= '0;
					l_q        <= '0;
					dot_norm_q <= (j_q == i_q);
				end
				S_DOT_W: l_q <= l_last ? '0 : l_q + LEN_AW'(1);
				S_DOT_X: begin
					k_q <= k_last ? '0 : k_q + LEN_AW'(1);
					if (k_last) begin
						after_q <= S_DOT_END;
					end
				end
				S_DOT_END: begin
					c_q <= n2_sat;
					k_q <= '0;
				end
				S_UPD: begin
					k_q <= k_last ? '0 : k_q + LEN_AW'(1);
					if (k_last) begin
						j_q     <= j_q + VEC_CW'(1);
						after_q <= S_PROJ;
					end
				end
				S_CHECK: begin
					k_q <= '0;
					if (skip_col) begin
						i_q <= i_q + VEC_CW'(1);
						if (skip_count_q != SKIP_MAX) begin
							skip_count_q <= skip_count_q + SKIP_W'(1);
						end
					end
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						k_q <= k_last ? '0 : k_q + LEN_AW'(1);
						if (k_last) begin
							i_q <= i_q + VEC_CW'(1);
						end
					end
				end
				S_DONE: begin
					done_q          <= 1'b1;
					is_run_status_q <= 1'b1;
					result_value_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		copy_k_s1 <= k_q;
	end

	// result write port: copy, update and normalise never overlap
	always_comb begin
		res_we    = copy_v_s1 | upd_we | div_wr;
		res_waddr = {i_a, k_q};
		res_wdata = div_quot;
		if (copy_v_s1) begin
			res_waddr = {i_a, copy_k_s1};
			res_wdata = basis_rdata;
		end else if (upd_we) begin
			res_waddr = {i_a, upd_row};
			res_wdata = upd_data;
		end
	end

	wgs_store #(
		.MAX_LEN  (MAX_LEN),
		.MAX_VECS (MAX_VECS)
	) u_store (
		.clk          (clk),
		.basis_we     (basis_we),
		.basis_waddr  ({in_col_b, in_row}),
		.basis_wdata  (element_value),
		.basis_raddr  (basis_raddr),
		.basis_rdata  (basis_rdata),
		.weight_we    (weight_we),
		.weight_waddr ({in_row, in_col_w}),
		.weight_wdata (element_value),
		.weight_raddr (weight_raddr),
		.weight_rdata (weight_rdata),
		.res_we       (res_we),
		.res_waddr    (res_waddr),
		.res_wdata    (res_wdata),
		.res_raddr_a  (res_raddr_a),
		.res_rdata_a  (res_rdata_a),
		.res_raddr_b  (res_raddr_b),
		.res_rdata_b  (res_rdata_b)
	);

	wgs_mac #(
		.LEN_AW (LEN_AW)
	) u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (mac_op),
		.op_row      (k_q),
		.w_rdata     (weight_rdata),
		.basis_rdata (basis_rdata),
		.res_a_rdata (res_rdata_a),
		.res_b_rdata (res_rdata_b),
		.coef        (c_q),
		.tot         (mac_tot),
		.upd_we      (upd_we),
		.upd_row     (upd_row),
		.upd_data    (upd_data),
		.busy        (mac_busy)
	);

	wgs_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (sqrt_value),
		.done   (sqrt_done),
		.root   (root)
	);

	wgs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.x       (res_rdata_a),
		.divisor (root),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign result_value    = result_value_q;
	assign skipped_columns = skip_count_q;
	assign is_run_status   = is_run_status_q;

`ifndef ASSERT_OFF
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({copy_v_s1, upd_we, div_wr}))
		else $error("result memory write collision");
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mac_busy)
		else $error("multiplier pipe active while idle");
	a_run_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_RUN) |=> busy)
		else $error("run beat not taken");
`endif

endmodule

### bench/weighted_gram_schmidt_unit_tb.sv
// testbench for the weighted gram-schmidt unit: directed and random command streams
// checked beat by beat against a predictor kept inside this file
// depends on wgs_pkg and weighted_gram_schmidt_unit
`timescale 1ns / 1ps

module weighted_gram_schmidt_unit_tb;
	import wgs_pkg::*;

	localparam int LEN_N       = 64;
	localparam int VECS_N      = 16;
	localparam int FILL_N      = 8;
	localparam int CYCLE_LIMIT = 2000000;
	localparam longint ONE_Q   = 64'sd1 <<< FRAC_W;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic [SKIP_W-1:0]        skips;
		logic                     is_run;
	} beat_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               command = '0;
	logic [IDX_W-1:0]         row_index = '0;
	logic [IDX_W-1:0]         col_index = '0;
	logic signed [DATA_W-1:0] element_value = '0;
	logic                     done;
	logic signed [DATA_W-1:0] result_value;
	logic [SKIP_W-1:0]        skipped_columns;
	logic                     is_run_status;
	logic                     cfg_write = 1'b0;
	logic [REG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;

	weighted_gram_schmidt_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .row_index(row_index), .col_index(col_index),
		.element_value(element_value), .done(done), .result_value(result_value),
		.skipped_columns(skipped_columns), .is_run_status(is_run_status),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic signed [DATA_W-1:0] basis_m [VECS_N][LEN_N];
	logic signed [DATA_W-1:0] weight_m [LEN_N][LEN_N];
	logic signed [DATA_W-1:0] ortho_m [VECS_N][LEN_N];
	longint                   x_vec [LEN_N];
	longint                   y_vec [LEN_N];
	logic [SKIP_W-1:0]        skip_m;
	logic [LEN_CFG_W-1:0]     len_m;
	logic [CNT_CFG_W-1:0]     cnt_m;
	logic [NORM_W-1:0]        min_norm_m;

	beat_t  pending_beats[$];
	logic   busy_s;
	logic   idle_on = 1'b1;
	int     error_count = 0;
	int     beats_checked = 0;
	int     items_sent = 0;
	int     runs_sent = 0;
	longint cycle_count = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		busy_s <= busy;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
				pending_beats.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		error_count++;
		$display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want,
			beats_checked);
	endtask

	always @(negedge clk) begin
		beat_t b;
		if (arst_n && done) begin
			if (pending_beats.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				b = pending_beats.pop_front();
				if (result_value !== b.value) report("result_value", result_value, b.value);
				if (skipped_columns !== b.skips)
					report("skipped_columns", skipped_columns, b.skips);
				if (is_run_status !== b.is_run) report("is_run_status", is_run_status, b.is_run);
				beats_checked++;
			end
		end
	end

	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 23)) >>> FRAC_W;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint wdot(input int n);
		longint tot;
		longint acc;
		tot = 0;
		for (int k = 0; k < n; k++) begin
			acc = 0;
			for (int l = 0; l < n; l++) acc += fx_mul(weight_m[k][l], y_vec[l]);
			tot += fx_mul(x_vec[k], clip32(acc));
		end
		return clip32(tot);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic void orthonormalise();
		int n;
		int m;
		int skips;
		longint c;
		longint n2;
		longint unsigned d;
		longint unsigned mag;
		longint unsigned qv;
		n = (len_m > LEN_N) ? LEN_N : len_m;
		m = (cnt_m > VECS_N) ? VECS_N : cnt_m;
		skips = 0;
		for (int i = 0; i < VECS_N; i++)
			for (int k = 0; k < LEN_N; k++) ortho_m[i][k] = '0;
		for (int i = 0; i < m; i++) begin
			for (int k = 0; k < n; k++) ortho_m[i][k] = basis_m[i][k];
			for (int j = 0; j < i; j++) begin
				for (int k = 0; k < n; k++) begin
					x_vec[k] = ortho_m[j][k];
					y_vec[k] = basis_m[i][k];
				end
				c = wdot(n);
				for (int k = 0; k < n; k++)
					ortho_m[i][k] = clip32(longint'(ortho_m[i][k]) - fx_mul(c, ortho_m[j][k]));
			end
			for (int k = 0; k < n; k++) begin
				x_vec[k] = ortho_m[i][k];
				y_vec[k] = ortho_m[i][k];
			end
			n2 = wdot(n);
			if (n2 < 0) n2 = 0;
			d = int_sqrt(longint'(n2) << FRAC_W);
			if (d == 0 || d < min_norm_m) begin
				if (skips < 31) skips++;
				continue;
			end
			for (int k = 0; k < n; k++) begin
				c = ortho_m[i][k];
				mag = (c < 0) ? -c : c;
				qv = (mag << FRAC_W) / d;
				if (c < 0)
					ortho_m[i][k] = (qv > 64'd2147483648) ? DATA_MIN : -longint'(qv);
				else
					ortho_m[i][k] = (qv > 64'd2147483647) ? DATA_MAX : qv;
			end
		end
		skip_m = skips;
	endfunction

	function automatic void predict_item(input cmd_t cmd, input int row, input int col,
			input logic signed [DATA_W-1:0] val);
		beat_t b;
		case (cmd)
			CMD_LOAD_BASIS: begin
				if (col < VECS_N) basis_m[col][row] = val;
			end
			CMD_LOAD_WEIGHT: begin
				weight_m[row][col] = val;
			end
			CMD_RUN: begin
				orthonormalise();
				b.value = '0;
				b.skips = skip_m;
				b.is_run = 1'b1;
				pending_beats.push_back(b);
			end
			default: begin
				b.value = (col < VECS_N) ? ortho_m[col][row] : '0;
				b.skips = skip_m;
				b.is_run = 1'b0;
				pending_beats.push_back(b);
			end
		endcase
	endfunction

	task automatic send(input cmd_t cmd, input int row, input int col,
			input logic signed [DATA_W-1:0] val);
		if (idle_on && $urandom_range(99) < 17) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		row_index <= row;
		col_index <= col;
		element_value <= val;
		do @(posedge clk); while (busy_s !== 1'b0);
		predict_item(cmd, row, col, val);
		items_sent++;
		if (cmd == CMD_RUN) runs_sent++;
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (pending_beats.size() != 0 || busy_s !== 1'b0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		wait_quiet();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_VECTOR_LENGTH: len_m = data[LEN_CFG_W-1:0];
			REG_VECTOR_COUNT:  cnt_m = data[CNT_CFG_W-1:0];
			default:           min_norm_m = data[NORM_W-1:0];
		endcase
	endtask

	task automatic configure(input int len, input int cnt, input logic [CFG_W-1:0] thr);
		set_reg(REG_VECTOR_LENGTH, len);
		set_reg(REG_VECTOR_COUNT, cnt);
		set_reg(REG_MIN_NORM, thr);
	endtask

	function automatic logic signed [DATA_W-1:0] small_val(input int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_elem();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? DATA_MAX : DATA_MIN;
			default: return small_val(1 << 25);
		endcase
	endfunction

	task automatic read_cols(input int rows, input int cols);
		for (int c = 0; c < cols; c++)
			for (int r = 0; r < rows; r++) send(CMD_READ, r, c, $urandom);
	endtask

	task automatic test_fill_stores();
		for (int c = 0; c < VECS_N; c++)
			for (int r = 0; r < FILL_N; r++) send(CMD_LOAD_BASIS, r, c, small_val(1 << 25));
		for (int r = 0; r < FILL_N; r++)
			for (int c = 0; c < FILL_N; c++)
				send(CMD_LOAD_WEIGHT, r, c, (r == c) ? ONE_Q : 0);
		// basis columns past the store are dropped
		send(CMD_LOAD_BASIS, 3, 40, DATA_MAX);
		send(CMD_LOAD_BASIS, 63, 63, DATA_MIN);
	endtask

	task automatic test_plain_run();
		configure(4, 3, 1);
		send(CMD_RUN, 0, 0, 0);
		read_cols(4, 3);
		send(CMD_READ, 5, 0, 0);
		send(CMD_READ, 0, 20, 0);
		send(CMD_READ, 63, 63, 0);
	endtask

	task automatic test_special_columns();
		// zero column, then a copy of column 0 that projects to nothing
		configure(3, 3, 0);
		for (int r = 0; r < 3; r++) begin
			send(CMD_LOAD_BASIS, r, 1, 0);
			send(CMD_LOAD_BASIS, r, 2, basis_m[0][r]);
		end
		send(CMD_RUN, 0, 0, 0);
		read_cols(3, 3);
		set_reg(REG_MIN_NORM, 31'h7fffffff);
		send(CMD_RUN, 0, 0, 0);
		send(CMD_READ, 0, 0, 0);
	endtask

	task automatic test_negative_weight();
		configure(2, 2, 1);
		for (int r = 0; r < 2; r++) send(CMD_LOAD_WEIGHT, r, r, -ONE_Q);
		send(CMD_RUN, 0, 0, 0);
		send(CMD_READ, 1, 1, 0);
		for (int r = 0; r < 2; r++) send(CMD_LOAD_WEIGHT, r, r, ONE_Q);
	endtask

	task automatic test_saturation();
		configure(2, 2, 1);
		send(CMD_LOAD_BASIS, 0, 0, DATA_MAX);
		send(CMD_LOAD_BASIS, 1, 0, DATA_MIN);
		send(CMD_LOAD_BASIS, 0, 1, DATA_MIN);
		send(CMD_LOAD_BASIS, 1, 1, 32'sh00000001);
		send(CMD_LOAD_WEIGHT, 0, 1, DATA_MAX);
		send(CMD_RUN, 0, 0, 0);
		read_cols(2, 2);
		send(CMD_LOAD_WEIGHT, 0, 1, 0);
	endtask

	task automatic test_length_count_limits();
		configure(0, 4, 1);
		send(CMD_RUN, 0, 0, 0);
		send(CMD_READ, 0, 2, 0);
		configure(5, 0, 1);
		send(CMD_RUN, 0, 0, 0);
		send(CMD_READ, 0, 0, 0);
		configure(FILL_N, 16, 1);
		send(CMD_RUN, 0, 0, 0);
		send(CMD_READ, FILL_N - 1, 15, 0);
		configure(2, 31, 1);
		send(CMD_RUN, 0, 0, 0);
		send(CMD_READ, 1, 15, 0);
	endtask

	task automatic test_random();
		int stop_at;
		int blk;
		int len;
		int cnt;
		int n;
		int m;
		int r;
		logic [CFG_W-1:0] thr;
		stop_at = items_sent + 450;
		blk = 0;
		while (items_sent < stop_at) begin
			idle_on = !(blk >= 5 && blk < 9);
			r = $urandom_range(99);
			if (r < 80) begin
				len = $urandom_range(1, FILL_N);
				cnt = $urandom_range(0, 6);
			end else if (r < 90) begin
				len = $urandom_range(1) ? 0 : FILL_N;
				cnt = $urandom_range(0, 3);
			end else if (r < 95) begin
				len = $urandom_range(1, 4);
				cnt = $urandom_range(16, 31);
			end else begin
				len = FILL_N;
				cnt = $urandom_range(7, VECS_N);
			end
			r = $urandom_range(9);
			thr = (r < 6) ? $urandom_range(0, 1 << 20) : (r < 8) ? 0 : $urandom;
			configure(len, cnt, thr);
			n = (len > LEN_N) ? LEN_N : len;
			m = (cnt > VECS_N) ? VECS_N : cnt;
			if (n <= 8 && $urandom_range(1)) begin
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++)
						send(CMD_LOAD_WEIGHT, i, j,
							(i == j) ? ONE_Q + small_val(1 << 20) : small_val(1 << 18));
			end
			if (n <= 16 || m <= 2) begin
				for (int c = 0; c < m; c++) begin
					r = $urandom_range(9);
					for (int k = 0; k < n; k++)
						send(CMD_LOAD_BASIS, k, c,
							(r == 0) ? 0 : (r == 1 && c > 0) ? basis_m[c-1][k] : rand_elem());
				end
			end
			repeat ($urandom_range(0, 4))
				send(cmd_t'($urandom_range(1)), $urandom_range(63), $urandom_range(63), $urandom);
			send(CMD_RUN, $urandom_range(63), $urandom_range(63), $urandom);
			repeat ($urandom_range(2, 8))
				send(CMD_READ, $urandom_range(63),
					$urandom_range(3) ? $urandom_range(VECS_N - 1) : $urandom_range(63), $urandom);
			blk++;
		end
		idle_on = 1'b1;
	endtask

	initial begin
		len_m = VECTOR_LENGTH_RST;
		cnt_m = VECTOR_COUNT_RST;
		min_norm_m = MIN_NORM_RST;
		skip_m = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_stores();
		test_plain_run();
		test_special_columns();
		test_negative_weight();
		test_saturation();
		test_length_count_limits();
		test_random();
		wait_quiet();
		repeat (50) @(posedge clk);
		$display("covered %0d commands with %0d runs, %0d beats checked", items_sent, runs_sent,
			beats_checked);
		$display("configs swept length 0..8, count 0..31, full threshold range");
		if (error_count == 0 && pending_beats.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
